### sv/pktk_pkg.sv
// Package: shared constants, types and state codes for the packed-sample top-K tracker.
`timescale 1ns / 1ps
package pktk_pkg;
    localparam int KEEP_COUNT = 32;
    localparam int BYTE_W     = 8;
    localparam int SAMPLE_W   = 12;
    localparam int RANK_PORT_W = 6;
    localparam int RANK_W     = (KEEP_COUNT > 1) ? $clog2(KEEP_COUNT) : 1;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = 12'h0FFF;

    typedef logic [SAMPLE_W-1:0] t_sample;
    typedef logic [BYTE_W-1:0]   t_byte;

    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_SECOND = 2'd1,
        PH_THIRD  = 2'd2
    } t_phase;

    // completed sample out of the unpacker
    typedef struct packed {
        logic    valid;
        t_sample sample;
    } t_sample_ev;

    // control broadcast to every list cell
    typedef struct packed {
        logic    insert;
        logic    shift;
        t_sample sample;
    } t_cell_ctl;
endpackage

### sv/pktk_if.sv
// Interfaces: byte input channel and kept-value output channel.
`timescale 1ns / 1ps
interface pktk_in_if;
    logic                      valid;
    logic                      ready;
    logic [pktk_pkg::BYTE_W-1:0] data_byte;
    logic                      end_of_data;
    modport source (output valid, data_byte, end_of_data, input ready);
    modport sink   (input valid, data_byte, end_of_data, output ready);
endinterface

interface pktk_out_if;
    logic                                valid;
    logic                                ready;
    logic [pktk_pkg::SAMPLE_W-1:0]       kept_value;
    logic [pktk_pkg::RANK_PORT_W-1:0]    rank;
    logic                                last_of_dump;
    modport source (output valid, kept_value, rank, last_of_dump, input ready);
    modport sink   (input valid, kept_value, rank, last_of_dump, output ready);
endinterface

### sv/pktk_unpack.sv
// Unpacker: joins three bytes into two 12-bit samples.
`timescale 1ns / 1ps
module pktk_unpack (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_take,
    input  logic                 i_clear,
    input  pktk_pkg::t_byte      i_byte,
    output pktk_pkg::t_sample_ev o_ev
);
    import pktk_pkg::*;

    t_phase r_phase, n_phase;
    t_byte  r_held, n_held;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_FIRST;
            r_held  <= '0;
        end else begin
            r_phase <= n_phase;
            r_held  <= n_held;
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_held       = r_held;
        o_ev.valid   = 1'b0;
        o_ev.sample  = '0;
        unique case (r_phase)
            PH_SECOND: begin
                o_ev.sample = {r_held, i_byte[7:4]} & SAMPLE_MASK;
                o_ev.valid  = i_take;
                if (i_take) n_phase = PH_THIRD;
            end
            PH_THIRD: begin
                o_ev.sample = {r_held[3:0], i_byte} & SAMPLE_MASK;
                o_ev.valid  = i_take;
                if (i_take) n_phase = PH_FIRST;
            end
            default: begin
                // unused code behaves as the first byte
                if (i_take) n_phase = PH_SECOND;
            end
        endcase
        if (i_take) n_held = i_byte;
        if (i_take && i_clear) begin
            n_phase = PH_FIRST;
            n_held  = '0;
        end
    end
endmodule

### sv/pktk_cell.sv
// List cell: one entry of the ascending list, insert-and-shift with its upper neighbor.
`timescale 1ns / 1ps
module pktk_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pktk_pkg::t_cell_ctl i_ctl,
    input  pktk_pkg::t_sample   i_up_value,
    input  logic                i_up_gt,
    output pktk_pkg::t_sample   o_value,
    output logic                o_gt
);
    import pktk_pkg::*;

    t_sample r_value, n_value;

    assign o_value = r_value;
    assign o_gt    = r_value < i_ctl.sample;

    always_comb begin
        n_value = r_value;
        if (i_ctl.shift) begin
            n_value = i_up_value;
        end else if (i_ctl.insert) begin
            // sample passes above this entry: take the neighbor's value
            if (i_up_gt)   n_value = i_up_value;
            else if (o_gt) n_value = i_ctl.sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value <= '0;
        end else begin
            r_value <= n_value;
        end
    end
endmodule

### sv/packed_sample_top_k_tracker_core.sv
// Top level: packed-sample top-K tracker built from a row of list cells.
//
//   channel  | dir | payload                           | transfer when
//   i_in     | in  | data_byte, end_of_data            | valid && ready
//   o_out    | out | kept_value, rank, last_of_dump    | valid && ready
//
// A completed sample goes into the cell row in the same cycle as the byte that completes it is taken.
// A byte flagged end_of_data starts a dump of KEEP_COUNT entries, one per output transfer,
// shifted out of the bottom cell; the input is not ready until the last entry is taken.
// Output stalls simply hold the row. Reset (synchronous, active low) clears the list to zeros.
`timescale 1ns / 1ps
module packed_sample_top_k_tracker_core (
    input logic        i_clk,
    input logic        i_rst_n,
    pktk_in_if.sink    i_in,
    pktk_out_if.source o_out
);
    import pktk_pkg::*;

    logic              r_dumping, n_dumping;
    logic [RANK_W-1:0] r_rank, n_rank;
    logic              in_take, out_take, dump_last;
    t_sample_ev        ev;
    t_cell_ctl         ctl;
    t_sample           values [KEEP_COUNT];
    logic              gts    [KEEP_COUNT];

    assign i_in.ready = !r_dumping;
    assign in_take    = i_in.valid && i_in.ready;
    assign out_take   = o_out.valid && o_out.ready;
    assign dump_last  = r_rank == RANK_W'(KEEP_COUNT - 1);

    pktk_unpack u_unpack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (in_take),
        .i_clear (i_in.end_of_data),
        .i_byte  (i_in.data_byte),
        .o_ev    (ev)
    );

    assign ctl.insert = ev.valid;
    assign ctl.shift  = out_take;
    assign ctl.sample = ev.sample;

    for (genvar g = 0; g < KEEP_COUNT; g++) begin : g_cell
        if (g == KEEP_COUNT - 1) begin : g_top
            pktk_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctl      (ctl),
                .i_up_value ('0),
                .i_up_gt    (1'b0),
                .o_value    (values[g]),
                .o_gt       (gts[g])
            );
        end else begin : g_mid
            pktk_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctl      (ctl),
                .i_up_value (values[g+1]),
                .i_up_gt    (gts[g+1]),
                .o_value    (values[g]),
                .o_gt       (gts[g])
            );
        end
    end

    always_comb begin
        n_dumping = r_dumping;
        n_rank    = r_rank;
        if (in_take && i_in.end_of_data) begin
            n_dumping = 1'b1;
            n_rank    = '0;
        end else if (out_take) begin
            if (dump_last) begin
                n_dumping = 1'b0;
                n_rank    = '0;
            end else begin
                n_rank = r_rank + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dumping <= 1'b0;
            r_rank    <= '0;
        end else begin
            r_dumping <= n_dumping;
            r_rank    <= n_rank;
        end
    end

    assign o_out.valid        = r_dumping;
    assign o_out.kept_value   = values[0];
    assign o_out.rank         = RANK_PORT_W'(r_rank);
    assign o_out.last_of_dump = dump_last;

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in.ready && o_out.valid))
        else $error("input ready during dump");

    a_dump_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_take && i_in.end_of_data) |=> (o_out.valid && r_rank == '0))
        else $error("dump did not start at rank zero");

    a_rank_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_take && !dump_last) |=> (o_out.valid && r_rank == $past(r_rank) + 1'b1))
        else $error("rank did not advance by one");

    a_dump_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_take && dump_last) |=> (!o_out.valid && values[0] == '0))
        else $error("list not cleared after dump");
endmodule
